@@ hdl/cnps_pkg.sv @@
// cnps_pkg: types and constants for the cosine nearest profile search.
// No dependencies.
package cnps_pkg;
  localparam int TRAITS = 5;
  localparam int MAX_PEOPLE = 256;
  localparam int IDX_W = $clog2(MAX_PEOPLE);
  localparam logic [2:0] ANS_MID = 3'd3;
  localparam int PROD_W = 32;
  localparam int SUM_W = 35;

  typedef struct packed {
    logic              func;
    logic [2:0]        answer;
    logic signed [15:0] trait_0;
    logic signed [15:0] trait_1;
    logic signed [15:0] trait_2;
    logic signed [15:0] trait_3;
    logic signed [15:0] trait_4;
    logic              last;
  } in_word_t;

  typedef struct packed {
    logic [7:0]         best_index;
    logic signed [15:0] best_similarity;
    logic               no_profile_error;
    logic signed [15:0] score_0;
    logic signed [15:0] score_1;
    logic signed [15:0] score_2;
    logic signed [15:0] score_3;
    logic signed [15:0] score_4;
  } out_word_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] dot;
    logic [PROD_W-1:0]        usq;
    logic [PROD_W-1:0]        csq;
  } lane_res_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

@@ hdl/cnps_lane.sv @@
// cnps_lane: one trait lane; score update and registered products.
// Depends on cnps_pkg.
module cnps_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      upd,
  input  logic                      load,
  input  logic [2:0]                answer,
  input  logic signed [15:0]        trait,
  output logic signed [15:0]        score,
  output cnps_pkg::lane_res_t       res
);
  import cnps_pkg::*;
  logic signed [15:0] score_r, score_nxt;
  logic signed [3:0]  fac;
  logic signed [20:0] acc;
  lane_res_t res_r;

  assign fac = $signed({1'b0, answer}) - $signed({1'b0, ANS_MID});
  assign acc = 21'(score_r) + 21'(trait) * 21'(fac);
  always_comb begin
    if (acc > 21'sd32767) score_nxt = 16'sh7fff;
    else if (acc < -21'sd32768) score_nxt = 16'sh8000;
    else score_nxt = acc[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) score_r <= '0;
    else if (upd) score_r <= score_nxt;
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r.dot <= PROD_W'(score_r) * PROD_W'(trait);
      res_r.usq <= PROD_W'(PROD_W'(score_r) * PROD_W'(score_r));
      res_r.csq <= PROD_W'(PROD_W'(trait) * PROD_W'(trait));
    end
  end

  assign score = score_r;
  assign res = res_r;
endmodule

@@ hdl/cnps_sqrt.sv @@
// cnps_sqrt: iterative integer square root, one result bit per cycle.
// Depends on cnps_pkg.
module cnps_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [cnps_pkg::SUM_W-1:0] n,
  output logic                       busy,
  output logic [17:0]                root
);
  import cnps_pkg::*;
  logic [35:0] rem_r, rem_nxt;
  logic [17:0] root_r, root_nxt;
  logic [35:0] num_r;
  logic [4:0]  cnt_r;
  logic        busy_r;
  logic [37:0] trial;
  logic [37:0] shrem;

  always_comb begin
    shrem = {rem_r, num_r[35:34]};
    trial = {18'd0, root_r, 2'b01};
    if (shrem >= trial) begin
      rem_nxt  = 36'(shrem - trial);
      root_nxt = {root_r[16:0], 1'b1};
    end else begin
      rem_nxt  = shrem[35:0];
      root_nxt = {root_r[16:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 5'd17;
    end else if (busy_r) begin
      if (cnt_r == 5'd0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= '0;
      root_r <= '0;
      num_r  <= 36'(n);
    end else if (busy_r) begin
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
      num_r  <= {num_r[33:0], 2'b00};
    end
  end

  assign busy = busy_r;
  assign root = root_r;
endmodule

@@ hdl/cnps_div.sv @@
// cnps_div: restoring divider producing a saturated 17-bit quotient.
// Depends on cnps_pkg.
module cnps_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cnps_pkg::div_ctl_t   ctl_in,
  input  logic [32:0]          mag,
  input  logic [35:0]          den,
  output logic                 busy,
  output logic [16:0]          quo
);
  import cnps_pkg::*;
  // quotient of (mag<<15)/den, clamped to 17 bits (>=131072 -> all ones is fine,
  // since caller clamps at 32767 or 32768)
  logic [47:0] num_r;
  logic [36:0] rem_r;
  logic [35:0] den_r;
  logic [16:0] q_r;
  logic        ovf_r;
  logic [5:0]  cnt_r;
  logic        busy_r;
  logic [37:0] sh;
  logic [37:0] dif;

  assign sh  = {rem_r, num_r[47]};
  assign dif = sh - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (ctl_in.start) begin
      busy_r <= 1'b1;
      cnt_r  <= 6'd47;
    end else if (busy_r) begin
      if (cnt_r == 6'd0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.start) begin
      num_r <= {mag, 15'd0};
      rem_r <= '0;
      den_r <= den;
      q_r   <= '0;
      ovf_r <= 1'b0;
    end else if (busy_r) begin
      num_r <= {num_r[46:0], 1'b0};
      if (!dif[37]) begin
        rem_r <= dif[36:0];
        if (q_r[16]) ovf_r <= 1'b1;
        q_r <= {q_r[15:0], 1'b1};
      end else begin
        rem_r <= sh[36:0];
        if (q_r[16]) ovf_r <= 1'b1;
        q_r <= {q_r[15:0], 1'b0};
      end
    end
  end

  assign busy = busy_r;
  assign quo  = ovf_r ? 17'h1ffff : q_r;
endmodule

@@ hdl/cosine_nearest_profile_search.sv @@
// cosine_nearest_profile_search: top level; five trait lanes, product adders,
// two square-root units and a divider. Depends on cnps_pkg and all cnps_ modules.
// channel | dir | ports
// in      | in  | in_valid, in_stall, in_data
// out     | out | out_valid, out_stall, out_data
// An answer word is taken without holding the input. A candidate word holds the input
// through product, sum, square root (18 steps), division (48 steps) and compare.
// Reset (rst_n low, synchronous) clears scores and the search.
// A result waits in the output register; the next word is taken meanwhile.
// A last candidate waits in compare while an earlier result is still stalled.
module cosine_nearest_profile_search (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cnps_pkg::in_word_t    in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cnps_pkg::out_word_t   out_data
);
  import cnps_pkg::*;
  localparam logic [2:0] S_IDLE = 3'd0, S_PROD = 3'd1, S_SUM = 3'd2,
                         S_SQRT = 3'd3, S_DIV = 3'd4, S_DONE = 3'd5;

  logic [2:0] st_r;
  logic       acc;
  logic       last_r;
  logic signed [15:0] trait [TRAITS];
  logic signed [15:0] score [TRAITS];
  lane_res_t res [TRAITS];
  logic signed [SUM_W-1:0] dot_r;
  logic [SUM_W-1:0] nu_r, nc_r;
  logic sq_start, sq_u_busy, sq_c_busy, div_busy;
  logic [17:0] su, sc;
  logic [16:0] quo;
  div_ctl_t dctl;
  logic [35:0] den;
  logic [32:0] mag;
  logic signed [15:0] sim;
  logic signed [15:0] best_sim_r;
  logic [IDX_W-1:0] best_idx_r, cnt_r;
  logic have_best_r;
  logic signed [SUM_W-1:0] dsum;
  logic [SUM_W-1:0] usum, csum;
  logic zero_user;
  logic done_go;

  assign trait[0] = in_data.trait_0;
  assign trait[1] = in_data.trait_1;
  assign trait[2] = in_data.trait_2;
  assign trait[3] = in_data.trait_3;
  assign trait[4] = in_data.trait_4;

  assign in_stall = (st_r != S_IDLE);
  assign acc = in_valid && !in_stall;

  for (genvar g = 0; g < TRAITS; g++) begin : g_lane
    cnps_lane u_lane (
      .clk(clk), .rst_n(rst_n),
      .upd(acc && !in_data.func), .load(acc && in_data.func),
      .answer(in_data.answer), .trait(trait[g]),
      .score(score[g]), .res(res[g]));
  end

  always_comb begin
    dsum = '0; usum = '0; csum = '0;
    for (int i = 0; i < TRAITS; i++) begin
      dsum = dsum + SUM_W'(res[i].dot);
      usum = usum + SUM_W'(res[i].usq);
      csum = csum + SUM_W'(res[i].csq);
    end
  end

  assign sq_start = (st_r == S_SUM);
  cnps_sqrt u_squ (.clk(clk), .rst_n(rst_n), .start(sq_start), .n(nu_r),
                   .busy(sq_u_busy), .root(su));
  cnps_sqrt u_sqc (.clk(clk), .rst_n(rst_n), .start(sq_start), .n(nc_r),
                   .busy(sq_c_busy), .root(sc));

  assign den = su * sc;
  assign mag = dot_r[SUM_W-1] ? 33'(-dot_r) : 33'(dot_r);
  assign dctl.start = (st_r == S_SQRT) && !sq_u_busy && !sq_c_busy && !sq_start;
  assign dctl.busy  = div_busy;
  cnps_div u_div (.clk(clk), .rst_n(rst_n), .ctl_in(dctl), .mag(mag), .den(den),
                  .busy(div_busy), .quo(quo));

  always_comb begin
    if (nu_r == '0 || nc_r == '0) sim = '0;
    else if (dot_r[SUM_W-1]) sim = (quo >= 17'd32768) ? 16'sh8000 : -$signed(quo[15:0]);
    else sim = (quo >= 17'd32767) ? 16'sh7fff : $signed(quo[15:0]);
  end

  assign zero_user = (score[0] == 0) && (score[1] == 0) && (score[2] == 0) &&
                     (score[3] == 0) && (score[4] == 0);

  assign done_go = (st_r == S_DONE) && !(last_r && out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (st_r == S_PROD) begin
      dot_r <= dsum;
      nu_r  <= usum;
      nc_r  <= csum;
    end
    if (acc) last_r <= in_data.last;
  end

  logic div_started_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
      best_sim_r <= '0;
      best_idx_r <= '0;
      cnt_r <= '0;
      have_best_r <= 1'b0;
      div_started_r <= 1'b0;
    end else begin
      if (done_go && last_r) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st_r)
        S_IDLE: if (acc && in_data.func) st_r <= S_PROD;
        S_PROD: st_r <= S_SUM;
        S_SUM:  st_r <= S_SQRT;
        S_SQRT: if (dctl.start) st_r <= S_DIV;
        S_DIV: begin
          if (div_started_r && !div_busy) begin
            div_started_r <= 1'b0;
            st_r <= S_DONE;
          end else begin
            div_started_r <= 1'b1;
          end
        end
        S_DONE: if (done_go) begin
          st_r <= S_IDLE;
          if (last_r) begin
            out_data.no_profile_error <= zero_user;
            out_data.best_index <= zero_user ? 8'd0 : 8'(
              (!have_best_r || sim > best_sim_r) ? cnt_r : best_idx_r);
            out_data.best_similarity <= zero_user ? 16'sd0 :
              ((!have_best_r || sim > best_sim_r) ? sim : best_sim_r);
            out_data.score_0 <= score[0];
            out_data.score_1 <= score[1];
            out_data.score_2 <= score[2];
            out_data.score_3 <= score[3];
            out_data.score_4 <= score[4];
            best_sim_r <= '0; best_idx_r <= '0; cnt_r <= '0; have_best_r <= 1'b0;
          end else begin
            if (!have_best_r || sim > best_sim_r) begin
              best_sim_r <= sim;
              best_idx_r <= cnt_r;
              have_best_r <= 1'b1;
            end
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> in_stall) else $error("accepted while busy");
  a_div_after_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    dctl.start |-> !sq_u_busy && !sq_c_busy) else $error("divide before roots");
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(st_r) == S_DONE) else $error("stray result");
endmodule
